// ===== hw/rtl/ppe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

	localparam int TIME_W   = 64;
	localparam int CLOCK_W  = 29;
	localparam int PERIOD_W = 32;
	localparam int COUNT_W  = 4;

	localparam logic [CLOCK_W-1:0] NOMINAL_RESET = CLOCK_W'(80000000);
	localparam logic [COUNT_W-1:0] COUNT_LIMIT   = COUNT_W'(8);

	// The window test only needs the low bits of the interval; anything at or above
	// 2^WIN_W ticks is far outside any window that a 29-bit nominal clock allows.
	localparam int WIN_W   = 34;
	localparam int TEN_W   = WIN_W + 4;
	localparam int NC9_W   = CLOCK_W + 4;

	// Dividend of the averaging division: interval plus up to seven 32-bit periods.
	localparam int DVD_W   = 36;
	localparam int DIVR_W  = 4;
	localparam int REM_W   = 3;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W  = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_CHECK,
		ST_NUM,
		ST_DIV,
		ST_FIN
	} ppe_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pps_period_estimator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pulse-per-second period estimator. One capture_time transaction is taken for each
// pulse edge and exactly one result is returned: the echoed timestamp, the period
// estimate after the pulse, and whether the interval fell inside the 90% to 110%
// window around nominal_clock and so updated the estimate. An interval in the window
// takes the delta, check, numerator and divide states before its result; the radix-2
// divider yields one quotient bit per cycle over a 36-bit dividend. An interval outside
// the window, or the first pulse, skips the divide. The next input transaction is
// taken once the previous one has left for the output register, which may still be
// waiting on out_ready. Writing nominal_clock reloads the period estimate.
module pps_period_estimator
	import ppe_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CLOCK_W-1:0]  cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [TIME_W-1:0]   capture_time,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [TIME_W-1:0]        pulse_time,
	output logic [PERIOD_W-1:0]      period_ticks,
	output logic                     accepted
);

	ppe_state_t state_q, state_d;

	logic [CLOCK_W-1:0]  nominal_q;
	logic [TIME_W-1:0]   prev_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   delta_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PERIOD_W-1:0] period_q;
	logic                took_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DIVR_W-1:0]   divr_q;
	logic [REM_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic [TIME_W-1:0]   pulse_time_q;
	logic [PERIOD_W-1:0] period_ticks_q;
	logic                accepted_q;

	logic                in_fire;
	logic                fin_fire;
	logic                div_last;
	logic                saturated;

	logic [TEN_W-1:0]    ten_d;
	logic [NC9_W-1:0]    nine_nc;
	logic [NC9_W-1:0]    eleven_nc;
	logic                in_window;

	logic [PERIOD_W+2:0] weighted;
	logic [DIVR_W-1:0]   trial;
	logic                qbit;
	logic [REM_W-1:0]    rem_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign saturated = count_q[COUNT_W-1];

	// delta >= floor(9n/10) is the same as 10*(delta+1) > 9n, and
	// delta <= floor(11n/10) is the same as 10*delta <= 11n.
	always_comb begin
		ten_d     = TEN_W'({delta_q[WIN_W-1:0], 3'b000})
			+ TEN_W'({delta_q[WIN_W-1:0], 1'b0});
		nine_nc   = {1'b0, nominal_q, 3'b000} + NC9_W'(nominal_q);
		eleven_nc = {1'b0, nominal_q, 3'b000} + {3'b000, nominal_q, 1'b0}
			+ NC9_W'(nominal_q);
		in_window = (prev_q != '0) && !(|delta_q[TIME_W-1:WIN_W])
			&& ((ten_d + TEN_W'(10)) > TEN_W'(nine_nc))
			&& (ten_d <= TEN_W'(eleven_nc));
	end

	always_comb begin
		weighted = {3'b000, period_q}
			* (PERIOD_W+3)'(saturated ? 3'd7 : count_q[2:0]);
		trial    = {rem_q, dvd_q[DVD_W-1]};
		qbit     = (trial >= divr_q);
		rem_d    = qbit ? REM_W'(trial - divr_q) : trial[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_DELTA;
			end
			ST_DELTA: state_d = ST_CHECK;
			ST_CHECK: state_d = in_window ? ST_NUM : ST_FIN;
			ST_NUM:   state_d = ST_DIV;
			ST_DIV: begin
				if (div_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_fire) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q   <= NOMINAL_RESET;
			period_q    <= PERIOD_W'(NOMINAL_RESET);
			prev_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				nominal_q <= cfg_data;
				period_q  <= PERIOD_W'(cfg_data);
			end else if (fin_fire && took_q) begin
				period_q <= dvd_q[PERIOD_W-1:0];
			end
			if (fin_fire) begin
				prev_q <= now_q;
				if (took_q && !saturated) count_q <= count_q + COUNT_W'(1);
			end
			out_valid_q <= fin_fire || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) now_q <= capture_time;
		if (state_q == ST_DELTA) delta_q <= now_q - prev_q;
		if (state_q == ST_CHECK) took_q <= in_window;
		if (state_q == ST_NUM) begin
			dvd_q  <= DVD_W'(delta_q[WIN_W-1:0]) + DVD_W'(weighted);
			divr_q <= saturated ? COUNT_LIMIT : count_q + DIVR_W'(1);
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], qbit};
			rem_q  <= rem_d;
			step_q <= step_q + STEP_W'(1);
		end
		if (fin_fire) begin
			pulse_time_q   <= now_q;
			period_ticks_q <= took_q ? dvd_q[PERIOD_W-1:0] : period_q;
			accepted_q     <= took_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_time   = pulse_time_q;
	assign period_ticks = period_ticks_q;
	assign accepted     = accepted_q;

`ifndef SYNTH
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (divr_q != '0))
		else $error("divider running with a zero divisor");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_LIMIT)
		else $error("sample count beyond its limit");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && took_q) |-> (dvd_q[DVD_W-1:PERIOD_W] == '0))
		else $error("averaged period does not fit in 32 bits");

	a_reject_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !in_window) |=> (state_q == ST_FIN))
		else $error("rejected interval did not go straight to the result");
`endif

endmodule

`default_nettype wire
